>>> src/lbm_pkg.sv
// Shared types and constants for the LED bar meter renderer.
`timescale 1ns / 1ps

package lbm_pkg;

   // Default number of LEDs that accept an override color
   localparam int MAX_LEDS_DEFAULT = 32;

   // Quotient bits resolved by one divider stage, and the divider geometry
   localparam int DIV_BITS = 2;
   localparam int IDX_W = 8;
   localparam int NUM_W = 16;
   localparam int PROD_W = 42;

   localparam logic [7:0] LEVEL_FULL = 8'd255;

   // Word carried down the pipeline
   typedef struct packed {
      logic [IDX_W-1:0]        idx;
      logic [IDX_W-1:0]        n;
      logic                    meter_on;
      logic                    ovr_en;
      logic [7:0]              ovr_red;
      logic [7:0]              ovr_green;
      logic [7:0]              ovr_blue;
      logic signed [32:0]      span;
      logic signed [32:0]      diff;
      logic signed [PROD_W-1:0] prod_idx;
      logic signed [PROD_W-1:0] prod_val;
      logic                    lit;
      logic [NUM_W-1:0]        num;
      logic [IDX_W-1:0]        den;
      logic [IDX_W-1:0]        rem;
      logic [IDX_W-1:0]        quo;
   } item_type;

endpackage

>>> src/lbm_div_step.sv
// Restoring divider slice: resolves DIV_BITS quotient bits of num / den.
`timescale 1ns / 1ps

module lbm_div_step (
   input  logic [lbm_pkg::IDX_W-1:0]    rem_in,
   input  logic [lbm_pkg::DIV_BITS-1:0] bits_in,
   input  logic [lbm_pkg::IDX_W-1:0]    den_in,
   output logic [lbm_pkg::IDX_W-1:0]    rem_out,
   output logic [lbm_pkg::DIV_BITS-1:0] quo_out
);

   // Shift in one dividend bit, subtract when it fits
   always_comb begin
      logic [lbm_pkg::IDX_W:0]   trial;
      logic [lbm_pkg::IDX_W-1:0] rem;
      rem = rem_in;
      quo_out = '0;
      for (int j = lbm_pkg::DIV_BITS - 1; j >= 0; j--) begin
         trial = {rem, bits_in[j]};
         if (trial >= {1'b0, den_in}) begin
            trial = trial - {1'b0, den_in};
            quo_out[j] = 1'b1;
         end
         rem = trial[lbm_pkg::IDX_W-1:0];
      end
      rem_out = rem;
   end

endmodule

>>> src/lbm_shade.sv
// Final color select: gradient, black, or per-pixel override.
`timescale 1ns / 1ps

module lbm_shade #(
   parameter int MAX_LEDS = lbm_pkg::MAX_LEDS_DEFAULT
) (
   input  lbm_pkg::item_type         item_in,
   input  logic [lbm_pkg::IDX_W-1:0] quo_in,
   input  logic                      rem_nz_in,
   output logic [7:0]                red_out,
   output logic [7:0]                green_out,
   output logic [7:0]                blue_out
);

   logic [8:0] ceil_q;

   assign ceil_q = {1'b0, quo_in} + {8'd0, rem_nz_in};

   always_comb begin
      red_out = '0;
      green_out = '0;
      blue_out = '0;
      if (item_in.idx < item_in.n) begin
         // lit LED: green at the bottom, red at the top
         if (item_in.lit) begin
            if (item_in.n > 8'd1) begin
               red_out = quo_in;
               green_out = 8'({1'b0, lbm_pkg::LEVEL_FULL} - ceil_q);
            end else begin
               green_out = lbm_pkg::LEVEL_FULL;
            end
         end
         // override applies only inside the addressable range
         if (item_in.ovr_en && ({1'b0, item_in.idx} < 9'(MAX_LEDS))) begin
            red_out = item_in.ovr_red;
            green_out = item_in.ovr_green;
            blue_out = item_in.ovr_blue;
         end
      end
   end

endmodule

>>> src/led_bar_meter_renderer.sv
// Top level of the LED bar meter renderer: five-stage pixel pipeline.
`timescale 1ns / 1ps

// One word in, one color word out, one per clock sustained while rsp_stall
// is low. Registers s1 to s5 hold each word: span and offset, the two meter
// products, the lit compare, and a four-stage restoring divider for the
// gradient (two quotient bits per stage) set the depth. Stages hand words
// forward independently, so empty stages fill while the output waits.
// led_count is sampled as each word enters; write it only while idle.

module led_bar_meter_renderer #(
   parameter int MAX_LEDS = lbm_pkg::MAX_LEDS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [7:0]         csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_led_index,
   input  logic               req_meter_enable,
   input  logic signed [31:0] req_meter_value,
   input  logic signed [31:0] req_meter_low,
   input  logic signed [31:0] req_meter_high,
   input  logic               req_override_enable,
   input  logic [7:0]         req_override_red,
   input  logic [7:0]         req_override_green,
   input  logic [7:0]         req_override_blue,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue
);

   logic [7:0] led_count_ff;

   lbm_pkg::item_type s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in, s4_ff, s4_in, s5_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic adv1, adv2, adv3, adv4, adv5;
   logic [7:0] red_ff, green_ff, blue_ff, red_in, green_in, blue_in;

   logic [lbm_pkg::IDX_W-1:0]    rem2, rem3, rem4, rem5;
   logic [lbm_pkg::DIV_BITS-1:0] q2, q3, q4, q5;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff <= '0;
      end else if (csr_write_enable) begin
         led_count_ff <= csr_write_data;
      end
   end

   // Stage handoff: a stage loads when empty or when its successor moves
   assign adv5 = !v5_ff || !rsp_stall;
   assign adv4 = !v4_ff || adv5;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_stall = !adv1;

   // Stage 1: span, offset from low, gradient dividend
   always_comb begin
      s1_in = '0;
      s1_in.idx = req_led_index;
      s1_in.n = led_count_ff;
      s1_in.meter_on = req_meter_enable;
      s1_in.ovr_en = req_override_enable;
      s1_in.ovr_red = req_override_red;
      s1_in.ovr_green = req_override_green;
      s1_in.ovr_blue = req_override_blue;
      s1_in.span = 33'(req_meter_high) - 33'(req_meter_low);
      s1_in.diff = 33'(req_meter_value) - 33'(req_meter_low);
      s1_in.num = {req_led_index, 8'd0} - {8'd0, req_led_index};
      s1_in.den = led_count_ff - 8'd1;
      s1_in.rem = s1_in.num[15:8];
   end

   // Stage 2: meter products, quotient bits 7:6
   lbm_div_step u_div2 (
      .rem_in(s1_ff.rem), .bits_in(s1_ff.num[7:6]), .den_in(s1_ff.den),
      .rem_out(rem2), .quo_out(q2)
   );

   always_comb begin
      s2_in = s1_ff;
      s2_in.prod_idx = lbm_pkg::PROD_W'($signed({1'b0, s1_ff.idx}))
                       * lbm_pkg::PROD_W'(s1_ff.span);
      s2_in.prod_val = lbm_pkg::PROD_W'(s1_ff.diff)
                       * lbm_pkg::PROD_W'($signed({1'b0, s1_ff.n}));
      s2_in.rem = rem2;
      s2_in.quo = {q2, 6'd0};
   end

   // Stage 3: lit decision, quotient bits 5:4
   lbm_div_step u_div3 (
      .rem_in(s2_ff.rem), .bits_in(s2_ff.num[5:4]), .den_in(s2_ff.den),
      .rem_out(rem3), .quo_out(q3)
   );

   always_comb begin
      s3_in = s2_ff;
      s3_in.lit = s2_ff.meter_on && (s2_ff.span > 33'sd0)
                  && (s2_ff.prod_idx < s2_ff.prod_val);
      s3_in.rem = rem3;
      s3_in.quo = {s2_ff.quo[7:6], q3, 4'd0};
   end

   // Stage 4: quotient bits 3:2
   lbm_div_step u_div4 (
      .rem_in(s3_ff.rem), .bits_in(s3_ff.num[3:2]), .den_in(s3_ff.den),
      .rem_out(rem4), .quo_out(q4)
   );

   always_comb begin
      s4_in = s3_ff;
      s4_in.rem = rem4;
      s4_in.quo = {s3_ff.quo[7:4], q4, 2'd0};
   end

   // Stage 5: last quotient bits and color select into the output register
   lbm_div_step u_div5 (
      .rem_in(s4_ff.rem), .bits_in(s4_ff.num[1:0]), .den_in(s4_ff.den),
      .rem_out(rem5), .quo_out(q5)
   );

   lbm_shade #(.MAX_LEDS(MAX_LEDS)) u_shade (
      .item_in(s4_ff), .quo_in({s4_ff.quo[7:2], q5}), .rem_nz_in(rem5 != '0),
      .red_out(red_in), .green_out(green_in), .blue_out(blue_in)
   );

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (adv1) s1_ff <= s1_in;
      if (adv2) s2_ff <= s2_in;
      if (adv3) s3_ff <= s3_in;
      if (adv4) s4_ff <= s4_in;
      if (adv5) begin
         s5_ff <= s4_ff;
         red_ff <= red_in;
         green_ff <= green_in;
         blue_ff <= blue_in;
      end
   end

   assign rsp_valid = v5_ff;
   assign rsp_red = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue = blue_ff;

   // LEDs past the end of the strip are always dark
   a_off_strip_black: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && (s5_ff.idx >= s5_ff.n)) |->
      (rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0))
      else $error("off-strip LED not black");

   // Blue can only come from an override
   a_blue_override: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && rsp_blue != 8'd0) |-> s5_ff.ovr_en)
      else $error("blue without override");

   // A word in stage 4 moves to the output when the output is free
   a_stage_flow: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && adv5) |=> v5_ff)
      else $error("word lost between stage 4 and output");

   // Gradient never lights red and green to full together
   a_gradient_sum: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && !s5_ff.ovr_en) |-> (9'(rsp_red) + 9'(rsp_green) <= 9'd255))
      else $error("gradient levels exceed full scale");

endmodule
